### sv/mpbm_pkg.sv
// mpbm_pkg: shared widths, constants, mode and register codes, and the structs
// passed between the stages of the masked pixel blender
// no dependencies
package mpbm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = 20;
    localparam int MASK_W     = FRAC_BITS + 1;
    localparam int PCT_W      = 7;
    localparam int PCT_MAX    = 100;
    localparam int PCT_ROUND  = PCT_MAX / 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // opacity * mask + rounding, and reciprocal of 100 for the weight
    localparam int WNUM_W      = 23;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_P_W   = WNUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((1 << RECIP_SHIFT) / PCT_MAX);

    localparam int MUL_W  = VAL_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int WW_W   = 2 * MASK_W;
    localparam int XP_W   = VAL_W + 4;

    // divider for vivid light
    localparam int NUM_W      = MASK_W + FRAC_BITS;
    localparam int DEN_W      = MASK_W;
    localparam int Q_W        = NUM_W;
    localparam int DIV_STAGES = NUM_W;

    localparam int X_W   = Q_W + 2;
    localparam int WT_W  = MASK_W + 1;
    localparam int PA_W  = VAL_W + WT_W;
    localparam int PX_W  = X_W + WT_W;
    localparam int SUM_W = PX_W + 1;

    localparam logic [MASK_W-1:0] ONE_M  = MASK_W'(1 << FRAC_BITS);
    localparam logic [MASK_W-1:0] HALF_M = MASK_W'(1 << (FRAC_BITS - 1));

    typedef enum logic [3:0] {
        MODE_NORMAL,
        MODE_BOUNDED,
        MODE_LIGHTEN,
        MODE_DARKEN,
        MODE_MULTIPLY,
        MODE_AVERAGE,
        MODE_ADD,
        MODE_SUBTRACT,
        MODE_DIFFERENCE,
        MODE_SCREEN,
        MODE_OVERLAY,
        MODE_SOFTLIGHT,
        MODE_HARDLIGHT,
        MODE_VIVIDLIGHT,
        MODE_LINEARLIGHT,
        MODE_PINLIGHT
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_MODE,
        CFG_SWAP,
        CFG_MASK_DISPLAY,
        CFG_OPACITY,
        CFG_MASK_INVERT
    } t_cfg_idx;

    typedef struct packed {
        t_mode             mode;
        logic              swap;
        logic              mask_display;
        logic [PCT_W-1:0]  opacity;
        logic              mask_invert;
    } t_cfg;

    // what the final mix needs, carried alongside the divider
    typedef struct packed {
        logic signed [VAL_W-1:0] base;
        logic signed [XP_W-1:0]  x_pre;
        logic [MASK_W-1:0]       weight;
        logic                    vsel;
        logic                    vneg;
    } t_mix_pl;

endpackage

### sv/mpbm_front.sv
// mpbm_front: five register stages that turn mask and opacity into the weight
// and build the mode term ahead of the divider; uses mpbm_pkg
module mpbm_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  mpbm_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    input  logic signed [mpbm_pkg::VAL_W-1:0] i_base,
    input  logic signed [mpbm_pkg::VAL_W-1:0] i_blend,
    input  logic [mpbm_pkg::MASK_W-1:0]       i_mask,
    output logic                              o_valid,
    output mpbm_pkg::t_mix_pl                 o_pl,
    output logic [mpbm_pkg::MASK_W-1:0]       o_num,
    output logic [mpbm_pkg::DEN_W-1:0]        o_den
);

    localparam int VAL_W  = mpbm_pkg::VAL_W;
    localparam int MASK_W = mpbm_pkg::MASK_W;
    localparam int WNUM_W = mpbm_pkg::WNUM_W;
    localparam int MUL_W  = mpbm_pkg::MUL_W;
    localparam int PROD_W = mpbm_pkg::PROD_W;
    localparam int WW_W   = mpbm_pkg::WW_W;
    localparam int XP_W   = mpbm_pkg::XP_W;
    localparam int FB     = mpbm_pkg::FRAC_BITS;

    localparam logic signed [VAL_W-1:0]  ONE_V  = VAL_W'(1 << FB);
    localparam logic signed [MUL_W-1:0]  ONE_S  = MUL_W'(1 << FB);
    localparam logic signed [MUL_W-1:0]  HALF_S = MUL_W'(1 << (FB - 1));
    localparam logic signed [XP_W-1:0]   ONE_X  = XP_W'(1 << FB);
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1 << (FB - 1));
    localparam logic [WW_W-1:0]          HALF_W = WW_W'(1 << (FB - 1));

    // stage 1
    logic                    r1_v;
    logic signed [VAL_W-1:0] r1_a, r1_b;
    logic [MASK_W-1:0]       r1_m;
    // stage 2
    logic                    r2_v;
    logic signed [VAL_W-1:0] r2_a, r2_b;
    logic [WNUM_W-1:0]       r2_xw;
    // stage 3
    logic                    r3_v;
    logic signed [VAL_W-1:0] r3_a, r3_b;
    logic [WNUM_W-1:0]       r3_xw;
    logic [MASK_W-1:0]       r3_q0;
    // stage 4
    logic                    r4_v;
    logic signed [VAL_W-1:0] r4_a, r4_b;
    logic [MASK_W-1:0]       r4_w;
    // stage 5
    logic                     r5_v;
    logic signed [PROD_W-1:0] r5_prod;
    logic [WW_W-1:0]          r5_ww;
    logic signed [XP_W-1:0]   r5_xs;
    logic                     r5_use_prod, r5_neg, r5_vsel, r5_vneg;
    logic signed [VAL_W-1:0]  r5_base;
    logic [MASK_W-1:0]        r5_w, r5_num;
    logic [mpbm_pkg::DEN_W-1:0] r5_den;

    // stage 1 logic
    logic [MASK_W-1:0]         m_c, m_i;
    logic [mpbm_pkg::PCT_W-1:0] pct_c;
    logic [WNUM_W-1:0]         n_xw;
    logic signed [VAL_W-1:0]   n_a, n_b;

    always_comb begin
        m_c   = (r1_m > mpbm_pkg::ONE_M) ? mpbm_pkg::ONE_M : r1_m;
        m_i   = i_cfg.mask_invert ? (mpbm_pkg::ONE_M - m_c) : m_c;
        pct_c = (i_cfg.opacity > mpbm_pkg::PCT_W'(mpbm_pkg::PCT_MAX)) ?
                mpbm_pkg::PCT_W'(mpbm_pkg::PCT_MAX) : i_cfg.opacity;
        n_xw  = WNUM_W'(pct_c) * WNUM_W'(m_i) + WNUM_W'(mpbm_pkg::PCT_ROUND);
        n_a   = i_cfg.swap ? r1_b : r1_a;
        n_b   = i_cfg.swap ? r1_a : r1_b;
    end

    // stage 2: reciprocal multiply
    logic [mpbm_pkg::RECIP_P_W-1:0] n_p;
    assign n_p = mpbm_pkg::RECIP_P_W'(r2_xw) * mpbm_pkg::RECIP_P_W'(mpbm_pkg::RECIP_100);

    // stage 3: quotient estimate is low by at most one
    logic [WNUM_W-1:0] rem;
    logic [MASK_W-1:0] n_w;
    always_comb begin
        rem = r3_xw - WNUM_W'(r3_q0) * WNUM_W'(mpbm_pkg::PCT_MAX);
        n_w = r3_q0 + MASK_W'(rem >= WNUM_W'(mpbm_pkg::PCT_MAX));
    end

    // stage 4: operand clipping, mode term, one product, weight square
    logic [MASK_W-1:0]        la, lb;
    logic                     la_hi, lb_hi;
    logic signed [MUL_W-1:0]  sla, slb, mul_a, mul_b;
    logic signed [XP_W-1:0]   xa, xb, xla, xlb, t_pin, n_xs;
    logic                     n_use_prod, n_neg, n_vsel, n_vneg;
    logic [MASK_W-1:0]        n_num;
    logic [mpbm_pkg::DEN_W-1:0] n_den;
    logic signed [VAL_W-1:0]  n_base;
    logic signed [PROD_W-1:0] n_prod;
    logic [WW_W-1:0]          n_ww;

    always_comb begin
        if (r4_a < 0) begin
            la = '0;
        end else if (r4_a > ONE_V) begin
            la = mpbm_pkg::ONE_M;
        end else begin
            la = r4_a[MASK_W-1:0];
        end
        if (r4_b < 0) begin
            lb = '0;
        end else if (r4_b > ONE_V) begin
            lb = mpbm_pkg::ONE_M;
        end else begin
            lb = r4_b[MASK_W-1:0];
        end
        la_hi = la > mpbm_pkg::HALF_M;
        lb_hi = lb > mpbm_pkg::HALF_M;
        sla   = $signed(MUL_W'(la));
        slb   = $signed(MUL_W'(lb));
        xa    = XP_W'(r4_a);
        xb    = XP_W'(r4_b);
        xla   = $signed(XP_W'(la));
        xlb   = $signed(XP_W'(lb));

        mul_a = '0;
        mul_b = '0;
        n_neg = 1'b0;
        n_use_prod = i_cfg.mode inside {mpbm_pkg::MODE_MULTIPLY, mpbm_pkg::MODE_SCREEN,
                                        mpbm_pkg::MODE_OVERLAY, mpbm_pkg::MODE_SOFTLIGHT,
                                        mpbm_pkg::MODE_HARDLIGHT};
        t_pin = lb_hi ? ((xlb <<< 1) - ONE_X) : (xlb <<< 1);
        n_xs  = '0;

        case (i_cfg.mode)
            mpbm_pkg::MODE_NORMAL, mpbm_pkg::MODE_BOUNDED: begin
                n_xs = xb;
            end
            mpbm_pkg::MODE_LIGHTEN: begin
                n_xs = (xa > xb) ? xa : xb;
            end
            mpbm_pkg::MODE_DARKEN: begin
                n_xs = (xa < xb) ? xa : xb;
            end
            mpbm_pkg::MODE_MULTIPLY: begin
                mul_a = MUL_W'(r4_a);
                mul_b = MUL_W'(r4_b);
            end
            mpbm_pkg::MODE_AVERAGE: begin
                n_xs = (xa + xb) >>> 1;
            end
            mpbm_pkg::MODE_ADD: begin
                n_xs = xa + xb;
            end
            mpbm_pkg::MODE_SUBTRACT: begin
                n_xs = xa + xb - ONE_X;
            end
            mpbm_pkg::MODE_DIFFERENCE: begin
                n_xs = (xa > xb) ? (xa - xb) : (xb - xa);
            end
            mpbm_pkg::MODE_SCREEN: begin
                mul_a = ONE_S - sla;
                mul_b = ONE_S - slb;
                n_neg = 1'b1;
            end
            mpbm_pkg::MODE_OVERLAY: begin
                if (la_hi) begin
                    mul_a = (ONE_S - sla) <<< 1;
                    mul_b = ONE_S - slb;
                    n_neg = 1'b1;
                end else begin
                    mul_a = sla <<< 1;
                    mul_b = slb;
                end
            end
            mpbm_pkg::MODE_HARDLIGHT: begin
                if (lb_hi) begin
                    mul_a = (ONE_S - sla) <<< 1;
                    mul_b = ONE_S - slb;
                    n_neg = 1'b1;
                end else begin
                    mul_a = sla <<< 1;
                    mul_b = slb;
                end
            end
            mpbm_pkg::MODE_SOFTLIGHT: begin
                if (lb_hi) begin
                    mul_a = ONE_S - sla;
                    mul_b = ONE_S + HALF_S - slb;
                    n_neg = 1'b1;
                end else begin
                    mul_a = sla;
                    mul_b = slb + HALF_S;
                end
            end
            mpbm_pkg::MODE_VIVIDLIGHT: begin
                // saturated ends that skip the divider
                n_xs = (lb >= mpbm_pkg::ONE_M) ? ONE_X : '0;
            end
            mpbm_pkg::MODE_LINEARLIGHT: begin
                n_xs = xla + (xlb <<< 1) - ONE_X;
            end
            mpbm_pkg::MODE_PINLIGHT: begin
                if (lb_hi) begin
                    n_xs = (xla > t_pin) ? xla : t_pin;
                end else begin
                    n_xs = (xla < t_pin) ? xla : t_pin;
                end
            end
            default: begin
                n_xs = '0;
            end
        endcase

        n_vsel = (i_cfg.mode == mpbm_pkg::MODE_VIVIDLIGHT) &&
                 (lb_hi ? (lb < mpbm_pkg::ONE_M) : (lb != '0));
        n_vneg = !lb_hi;
        n_num  = lb_hi ? la : (mpbm_pkg::ONE_M - la);
        n_den  = lb_hi ? ((mpbm_pkg::ONE_M - lb) << 1) : (lb << 1);
        n_base = (i_cfg.mode >= mpbm_pkg::MODE_SCREEN) ? VAL_W'(sla) : r4_a;
        n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
        n_ww   = WW_W'(r4_w) * WW_W'(r4_w);
    end

    // stage 5: round the product, pick the term and the weight
    logic signed [PROD_W-1:0] rs;
    logic signed [XP_W-1:0]   mq, term;
    logic [WW_W-1:0]          ws;

    always_comb begin
        rs   = (r5_prod + HALF_P) >>> FB;
        mq   = rs[XP_W-1:0];
        term = r5_neg ? (ONE_X - mq) : mq;
        ws   = (r5_ww + HALF_W) >> FB;
        o_pl.base   = r5_base;
        o_pl.x_pre  = r5_use_prod ? term : r5_xs;
        o_pl.weight = (i_cfg.mode >= mpbm_pkg::MODE_OVERLAY) ? ws[MASK_W-1:0] : r5_w;
        o_pl.vsel   = r5_vsel;
        o_pl.vneg   = r5_vneg;
    end

    assign o_valid = r5_v;
    assign o_num   = r5_num;
    assign o_den   = r5_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a        <= i_base;
            r1_b        <= i_blend;
            r1_m        <= i_mask;
            r2_a        <= n_a;
            r2_b        <= n_b;
            r2_xw       <= n_xw;
            r3_a        <= r2_a;
            r3_b        <= r2_b;
            r3_xw       <= r2_xw;
            r3_q0       <= n_p[mpbm_pkg::RECIP_SHIFT +: MASK_W];
            r4_a        <= r3_a;
            r4_b        <= r3_b;
            r4_w        <= n_w;
            r5_prod     <= n_prod;
            r5_ww       <= n_ww;
            r5_xs       <= n_xs;
            r5_use_prod <= n_use_prod;
            r5_neg      <= n_neg;
            r5_vsel     <= n_vsel;
            r5_vneg     <= n_vneg;
            r5_base     <= n_base;
            r5_w        <= r4_w;
            r5_num      <= n_num;
            r5_den      <= n_den;
        end
    end

endmodule

### sv/mpbm_div.sv
// mpbm_div: pipelined restoring divider, one quotient bit per stage, carrying
// the mix payload alongside; uses mpbm_pkg
module mpbm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  mpbm_pkg::t_mix_pl             i_pl,
    input  logic [mpbm_pkg::MASK_W-1:0]   i_num,
    input  logic [mpbm_pkg::DEN_W-1:0]    i_den,
    output logic                          o_valid,
    output mpbm_pkg::t_mix_pl             o_pl,
    output logic [mpbm_pkg::Q_W-1:0]      o_quo
);

    localparam int NS    = mpbm_pkg::DIV_STAGES;
    localparam int NUM_W = mpbm_pkg::NUM_W;
    localparam int DEN_W = mpbm_pkg::DEN_W;
    localparam int Q_W   = mpbm_pkg::Q_W;

    logic              r_v   [NS];
    mpbm_pkg::t_mix_pl r_pl  [NS];
    logic [DEN_W-1:0]  r_rem [NS];
    logic [DEN_W-1:0]  r_den [NS];
    logic [NUM_W-1:0]  r_num [NS];
    logic [Q_W-1:0]    r_quo [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic              v_p;
        mpbm_pkg::t_mix_pl pl_p;
        logic [DEN_W-1:0]  rem_p, den_p, n_rem;
        logic [NUM_W-1:0]  num_p;
        logic [Q_W-1:0]    quo_p;
        logic [DEN_W:0]    trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_p   = i_valid;
            assign pl_p  = i_pl;
            assign rem_p = '0;
            assign den_p = i_den;
            assign num_p = {i_num, {mpbm_pkg::FRAC_BITS{1'b0}}};
            assign quo_p = '0;
        end else begin : g_next
            assign v_p   = r_v[k-1];
            assign pl_p  = r_pl[k-1];
            assign rem_p = r_rem[k-1];
            assign den_p = r_den[k-1];
            assign num_p = r_num[k-1];
            assign quo_p = r_quo[k-1];
        end

        always_comb begin
            trial = {rem_p, num_p[NUM_W-1]};
            ge    = trial >= {1'b0, den_p};
            n_rem = ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_p;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pl[k]  <= pl_p;
                r_rem[k] <= n_rem;
                r_den[k] <= den_p;
                r_num[k] <= num_p << 1;
                r_quo[k] <= {quo_p[Q_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_pl    = r_pl[NS-1];
    assign o_quo   = r_quo[NS-1];

endmodule

### sv/mpbm_mix.sv
// mpbm_mix: final weighted mix of base and mode term, rounding, clamping and
// mask display, two register stages; uses mpbm_pkg
module mpbm_mix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  mpbm_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    input  mpbm_pkg::t_mix_pl                 i_pl,
    input  logic [mpbm_pkg::Q_W-1:0]          i_quo,
    output logic                              o_valid,
    output logic signed [mpbm_pkg::VAL_W-1:0] o_value
);

    localparam int FB    = mpbm_pkg::FRAC_BITS;
    localparam int VAL_W = mpbm_pkg::VAL_W;
    localparam int X_W   = mpbm_pkg::X_W;
    localparam int WT_W  = mpbm_pkg::WT_W;
    localparam int PA_W  = mpbm_pkg::PA_W;
    localparam int PX_W  = mpbm_pkg::PX_W;
    localparam int SUM_W = mpbm_pkg::SUM_W;

    localparam logic signed [X_W-1:0]   ONE_X  = X_W'(1 << FB);
    localparam logic signed [WT_W-1:0]  ONE_T  = WT_W'(1 << FB);
    localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(1 << (FB - 1));
    localparam logic signed [SUM_W-1:0] ONE_S  = SUM_W'(1 << FB);
    localparam logic signed [SUM_W-1:0] MAX_S  = SUM_W'((1 << (VAL_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MIN_S  = -SUM_W'(1 << (VAL_W - 1));

    logic                    r1_v, r2_v;
    logic signed [PA_W-1:0]  r1_pa;
    logic signed [PX_W-1:0]  r1_px;
    logic signed [VAL_W-1:0] r2_val;

    logic signed [X_W-1:0]   x;
    logic signed [WT_W-1:0]  wt, wc;
    logic signed [PA_W-1:0]  n_pa;
    logic signed [PX_W-1:0]  n_px;

    always_comb begin
        if (i_pl.vsel) begin
            x = i_pl.vneg ? (ONE_X - $signed(X_W'(i_quo))) : $signed(X_W'(i_quo));
        end else begin
            x = X_W'(i_pl.x_pre);
        end
        wt   = $signed(WT_W'(i_pl.weight));
        wc   = ONE_T - wt;
        n_pa = PA_W'(i_pl.base) * PA_W'(wc);
        n_px = PX_W'(x) * PX_W'(wt);
    end

    logic signed [SUM_W-1:0] s, r;
    logic signed [VAL_W-1:0] n_val;

    always_comb begin
        s = SUM_W'(r1_pa) + SUM_W'(r1_px) + HALF_S;
        r = s >>> FB;
        if (i_cfg.mask_display) begin
            n_val = '0;
        end else if (i_cfg.mode == mpbm_pkg::MODE_NORMAL) begin
            // unbounded normal saturates to the field range
            if (r > MAX_S) begin
                n_val = MAX_S[VAL_W-1:0];
            end else if (r < MIN_S) begin
                n_val = MIN_S[VAL_W-1:0];
            end else begin
                n_val = r[VAL_W-1:0];
            end
        end else begin
            if (r < 0) begin
                n_val = '0;
            end else if (r > ONE_S) begin
                n_val = ONE_S[VAL_W-1:0];
            end else begin
                n_val = r[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pa  <= n_pa;
            r1_px  <= n_px;
            r2_val <= n_val;
        end
    end

    assign o_valid = r2_v;
    assign o_value = r2_val;

endmodule

### sv/masked_pixel_blend_modes.sv
// Masked single-channel pixel blender with sixteen blend modes. One beat per clock is
// taken while o_stall is low and one result beat comes out per input beat, in order;
// a result passes through 5 front stages for weight and mode term, 33 divider stages,
// 2 mix stages and 1 output buffer stage. The depth is set by the
// one-bit-per-stage divider used by vivid light, which every beat passes through.
// A two-entry output buffer lets input flow on while one result waits; o_stall
// rises only when both entries are full. Registers are written through the plain
// write port and should change only while no beat is in flight.
module masked_pixel_blend_modes (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [mpbm_pkg::VAL_W-1:0]    i_base_value,
    input  logic signed [mpbm_pkg::VAL_W-1:0]    i_blend_value,
    input  logic [mpbm_pkg::MASK_W-1:0]          i_mask_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [mpbm_pkg::VAL_W-1:0]    o_blended_value,
    input  logic                                 i_cfg_we,
    input  logic [mpbm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mpbm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int VAL_W = mpbm_pkg::VAL_W;

    mpbm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= mpbm_pkg::MODE_NORMAL;
            r_cfg.swap         <= 1'b0;
            r_cfg.mask_display <= 1'b0;
            r_cfg.opacity      <= mpbm_pkg::PCT_W'(mpbm_pkg::PCT_MAX);
            r_cfg.mask_invert  <= 1'b0;
        end else if (i_cfg_we) begin
            case (mpbm_pkg::t_cfg_idx'(i_cfg_idx))
                mpbm_pkg::CFG_BLEND_MODE:   r_cfg.mode <= mpbm_pkg::t_mode'(i_cfg_data[3:0]);
                mpbm_pkg::CFG_SWAP:         r_cfg.swap <= i_cfg_data[0];
                mpbm_pkg::CFG_MASK_DISPLAY: r_cfg.mask_display <= i_cfg_data[0];
                mpbm_pkg::CFG_OPACITY:      r_cfg.opacity <= i_cfg_data[mpbm_pkg::PCT_W-1:0];
                mpbm_pkg::CFG_MASK_INVERT:  r_cfg.mask_invert <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // whole pipeline advances unless the output buffer is full
    logic [1:0] r_cnt;
    logic       en;
    assign en      = (r_cnt != 2'd2);
    assign o_stall = !en;

    logic                    f_valid, d_valid, m_valid;
    mpbm_pkg::t_mix_pl       f_pl, d_pl;
    logic [mpbm_pkg::MASK_W-1:0] f_num;
    logic [mpbm_pkg::DEN_W-1:0]  f_den;
    logic [mpbm_pkg::Q_W-1:0]    d_quo;
    logic signed [VAL_W-1:0]     m_value;

    mpbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_base  (i_base_value),
        .i_blend (i_blend_value),
        .i_mask  (i_mask_value),
        .o_valid (f_valid),
        .o_pl    (f_pl),
        .o_num   (f_num),
        .o_den   (f_den)
    );

    mpbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_pl    (f_pl),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_valid (d_valid),
        .o_pl    (d_pl),
        .o_quo   (d_quo)
    );

    mpbm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_valid (d_valid),
        .i_pl    (d_pl),
        .i_quo   (d_quo),
        .o_valid (m_valid),
        .o_value (m_value)
    );

    // two-entry output buffer, head in r_e0
    logic signed [VAL_W-1:0] r_e0, r_e1;
    logic                    push, pop;

    assign push = en && m_valid;
    assign pop  = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)) begin
                r_e0 <= m_value;
            end else begin
                r_e1 <= m_value;
            end
        end
        if (pop && r_cnt == 2'd2) begin
            r_e0 <= r_e1;
        end
    end

    assign o_valid         = (r_cnt != 2'd0);
    assign o_blended_value = r_e0;

endmodule

### sv/mpbm_checker.sv
// mpbm_checker: port-level checks on the blender's output buffer and stall,
// bound to masked_pixel_blend_modes; uses mpbm_pkg
module mpbm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [mpbm_pkg::VAL_W-1:0]    o_blended_value
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blended_value))
        else $error("output beat changed while stalled");

    // input is only held off when a result is waiting
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // buffer only fills up when the output side held a beat back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("stall raised without a held output beat");

    // reset empties the buffer
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("output buffer not empty after reset");

endmodule

bind masked_pixel_blend_modes mpbm_checker u_mpbm_checker (.*);

### tb/sv/masked_pixel_blend_modes_tb.sv
// masked_pixel_blend_modes_tb: self-checking bench for the masked pixel blender
// drives pixel beats and register writes, predicts each result in-bench
// depends on mpbm_pkg and masked_pixel_blend_modes
module masked_pixel_blend_modes_tb;
    import mpbm_pkg::*;

    localparam longint ONE_V = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF_V = ONE_V >>> 1;
    localparam longint BIG_V = 64'sd1 <<< 36;
    localparam int WATCH_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic signed [VAL_W-1:0] i_base_value;
    logic signed [VAL_W-1:0] i_blend_value;
    logic [MASK_W-1:0] i_mask_value;
    logic o_valid;
    logic i_stall;
    logic signed [VAL_W-1:0] o_blended_value;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    masked_pixel_blend_modes uut (.*);

    // shadow copy of the registers
    t_mode sh_mode;
    logic sh_swap, sh_disp, sh_inv;
    logic [PCT_W-1:0] sh_pct;

    logic signed [VAL_W-1:0] pixel_q[$];
    int errors, beats_in, beats_out, watch;
    bit idle_ok;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint rnd(longint v);
        longint t;
        t = v + HALF_V;
        return t >>> FRAC_BITS;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mixw(longint a, longint x, longint w);
        return rnd(a * (ONE_V - w) + x * w);
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
        return q;
    endfunction

    function automatic longint light(t_mode md, longint la, longint lb);
        longint t;
        case (md)
            MODE_OVERLAY: return la > HALF_V ?
                ONE_V - rnd((ONE_V - 2 * (la - HALF_V)) * (ONE_V - lb)) : rnd(2 * la * lb);
            MODE_SOFTLIGHT: return lb > HALF_V ?
                ONE_V - rnd((ONE_V - la) * (ONE_V - (lb - HALF_V))) : rnd(la * (lb + HALF_V));
            MODE_HARDLIGHT: return lb > HALF_V ?
                ONE_V - rnd((ONE_V - 2 * (la - HALF_V)) * (ONE_V - lb)) : rnd(2 * la * lb);
            MODE_VIVIDLIGHT: begin
                if (lb > HALF_V) begin
                    if (lb >= ONE_V) return ONE_V;
                    return fdiv(la * ONE_V, 2 * (ONE_V - lb));
                end
                if (lb <= 0) return 0;
                return ONE_V - fdiv((ONE_V - la) * ONE_V, 2 * lb);
            end
            MODE_LINEARLIGHT: return la + 2 * lb - ONE_V;
            default: begin
                if (lb > HALF_V) begin
                    t = 2 * (lb - HALF_V);
                    return la > t ? la : t;
                end
                t = 2 * lb;
                return la < t ? la : t;
            end
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] blend_pixel_of(longint a0, longint b0,
                                                                 longint m0);
        longint a, b, m, w, w2, x, la, lb, r, p, s;
        if (sh_disp) return '0;
        p = sh_pct > PCT_MAX ? PCT_MAX : sh_pct;
        m = m0 > ONE_V ? ONE_V : m0;
        if (sh_inv) m = ONE_V - m;
        w = (p * m + 50) / 100;
        a = sh_swap ? b0 : a0;
        b = sh_swap ? a0 : b0;
        if (sh_mode == MODE_NORMAL) begin
            r = mixw(a, b, w);
        end else if (sh_mode >= MODE_SCREEN) begin
            la = clampv(a, 0, ONE_V);
            lb = clampv(b, 0, ONE_V);
            if (sh_mode == MODE_SCREEN) begin
                r = clampv(mixw(la, ONE_V - rnd((ONE_V - la) * (ONE_V - lb)), w), 0, ONE_V);
            end else begin
                w2 = (w * w + HALF_V) >>> FRAC_BITS;
                x = light(sh_mode, la, lb);
                if (w2 != 0 && x > BIG_V && x > (ONE_V <<< FRAC_BITS) / w2) r = ONE_V;
                else if (w2 != 0 && x < -BIG_V && x < -((ONE_V <<< FRAC_BITS) * 2) / w2)
                    r = 0;
                else r = clampv(mixw(la, x, w2), 0, ONE_V);
            end
        end else begin
            case (sh_mode)
                MODE_BOUNDED: x = b;
                MODE_LIGHTEN: x = a > b ? a : b;
                MODE_DARKEN: x = a < b ? a : b;
                MODE_MULTIPLY: x = rnd(a * b);
                MODE_AVERAGE: begin
                    s = a + b;
                    x = s >>> 1;
                end
                MODE_ADD: x = a + b;
                MODE_SUBTRACT: x = a + b - ONE_V;
                default: x = a > b ? a - b : b - a;
            endcase
            r = clampv(mixw(a, x, w), 0, ONE_V);
        end
        return VAL_W'(clampv(r, -524288, 524287));
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // receiver: random stall bursts, checks each result beat
    initial begin
        int burst;
        logic signed [VAL_W-1:0] want;
        i_stall <= 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                beats_out++;
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_blended_value, 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (o_blended_value !== want)
                        report_mismatch("blended_value", o_blended_value, want);
                end
            end
            if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (idle_ok && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 10) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        watch = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) watch = 0;
            else watch++;
            if (watch >= WATCH_LIMIT) begin
                $display("watchdog expired");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BLEND_MODE: sh_mode = t_mode'(val[3:0]);
            CFG_SWAP: sh_swap = val[0];
            CFG_MASK_DISPLAY: sh_disp = val[0];
            CFG_OPACITY: sh_pct = val[PCT_W-1:0];
            default: sh_inv = val[0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // one beat; with idle_ok set, a random idle burst is sometimes inserted before it
    task automatic send_pixel(longint a, longint b, longint m, logic [VAL_W-1:0] want,
                              bit typed);
        if (idle_ok && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_base_value <= VAL_W'(a);
        i_blend_value <= VAL_W'(b);
        i_mask_value <= MASK_W'(m);
        pixel_q.push_back(typed ? want : blend_pixel_of(a, b, m));
        beats_in++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    typedef struct {
        int a;
        int b;
        int m;
        int want;
        bit typed;
    } t_row;

    t_row rows[] = '{
        '{0, 0, 0, 0, 1},
        '{524287, -524288, 65536, -524288, 1},
        '{-524288, 524287, 65536, 524287, 1},
        '{524287, -524288, 0, 524287, 1},
        '{-524288, 0, 0, -524288, 1},
        '{65536, 32768, 131071, 32768, 1},
        '{12345, 54321, 32768, 0, 0},
        '{-1, 1, 1, 0, 0},
        '{70000, -3000, 65535, 0, 0}
    };

    function automatic int rand_val(int mode_sel);
        case (mode_sel)
            0: return $urandom_range(0, 65536);
            1: return int'($urandom_range(0, 1048575)) - 524288;
            2: return $urandom_range(0, 1) ? 0 : (($urandom_range(0, 1)) ? 65536 : 32768);
            default: return int'($urandom_range(0, 140000)) - 70000;
        endcase
    endfunction

    initial begin
        int md, k, n;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        idle_ok = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_base_value <= '0;
        i_blend_value <= '0;
        i_mask_value <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        sh_mode = MODE_NORMAL;
        sh_swap = 0;
        sh_disp = 0;
        sh_pct = 100;
        sh_inv = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: unbounded normal at full opacity
        foreach (rows[i]) send_pixel(rows[i].a, rows[i].b, rows[i].m, VAL_W'(rows[i].want),
                                     rows[i].typed);
        i_valid <= 1'b0;
        drain();
        // every mode once with edge values, then mask display, invert, swap
        for (md = 0; md < 16; md++) begin
            cfg_write(CFG_BLEND_MODE, md);
            send_pixel(40000, 50000, 65536, '0, 0);
            send_pixel(65536, 0, 30000, '0, 0);
            i_valid <= 1'b0;
            drain();
        end
        cfg_write(CFG_MASK_DISPLAY, 1);
        send_pixel(524287, 524287, 65536, '0, 1);
        i_valid <= 1'b0;
        drain();
        cfg_write(CFG_MASK_DISPLAY, 0);
        cfg_write(CFG_OPACITY, 127);
        cfg_write(CFG_MASK_INVERT, 1);
        cfg_write(CFG_SWAP, 1);
        send_pixel(10000, 60000, 0, '0, 0);
        i_valid <= 1'b0;
        drain();

        // random phases, each with its own register settings
        idle_ok = 1;
        for (k = 0; k < 31; k++) begin
            cfg_write(CFG_BLEND_MODE, k < 16 ? k : $urandom_range(0, 15));
            cfg_write(CFG_SWAP, $urandom_range(0, 1));
            cfg_write(CFG_MASK_DISPLAY, $urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
                0: cfg_write(CFG_OPACITY, 0);
                1: cfg_write(CFG_OPACITY, 100);
                2: cfg_write(CFG_OPACITY, $urandom_range(101, 127));
                default: cfg_write(CFG_OPACITY, $urandom_range(0, 100));
            endcase
            cfg_write(CFG_MASK_INVERT, $urandom_range(0, 1));
            if (k == 28) idle_ok = 0;
            for (n = 0; n < 50; n++)
                send_pixel(rand_val($urandom_range(0, 3)), rand_val($urandom_range(0, 3)),
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, 65536), '0, 0);
            i_valid <= 1'b0;
            drain();
        end

        $display("%0d pixel beats sent, %0d result beats checked", beats_in, beats_out);
        $display("covered all sixteen modes, swap, invert, mask display, opacity extremes");
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
